// File: design/plim_pkg.sv
// shared types and constants for the peak limiter
`default_nettype none

package plim_pkg;

	// gain, register and field widths
	localparam int GAIN_W    = 16;
	localparam int CEIL_W    = 16;
	localparam int COEF_W    = 24;
	localparam int CH_W      = 3;
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = 4;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

	// configuration register defaults
	localparam logic [CEIL_W-1:0] CEILING_RST = 16'd29205;
	localparam logic [COEF_W-1:0] COEF_RST    = 24'd6990;

	// register decode, selected by paddr bit 2
	localparam logic REG_CEILING = 1'b0;
	localparam logic REG_COEF    = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic rel;
		logic mul;
		logic div_init;
		logic div_step;
		logic commit;
	} plim_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic over;
		logic div_last;
		logic out_full;
	} plim_sts_t;

endpackage

`default_nettype wire

// File: design/plim_if.sv
// stream interfaces for the sample word and the result word
`default_nettype none

interface plim_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [2:0]                    channel;
	logic                          frame_first;

	modport source (output valid, output sample_in, output channel, output frame_first,
		input ready);
	modport sink (input valid, input sample_in, input channel, input frame_first,
		output ready);
endinterface

interface plim_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [15:0]                   gain_applied;
	logic [15:0]                   frame_min_gain;

	modport source (output valid, output sample_out, output gain_applied,
		output frame_min_gain, input ready);
	modport sink (input valid, input sample_out, input gain_applied,
		input frame_min_gain, output ready);
endinterface

`default_nettype wire

// File: design/plim_ctrl.sv
// sequencing state machine of the peak limiter
`default_nettype none

module plim_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire plim_pkg::plim_sts_t sts,
	output plim_pkg::plim_cmd_t     cmd
);
	import plim_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_REL  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_CHK  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_REL;
				end
			end
			ST_REL: begin
				cmd.rel = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.over) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				// hold until the output register can take the word
				if (!sts.out_full) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a word is captured only in the idle state, and the capture starts the release step
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_REL)
		else $error("capture did not start the release step");

	// the divider is left only after its last step
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> state_q == ST_DIV)
		else $error("divider left early");

	// no commit while the output register is still held
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_full)
		else $error("commit into a full output register");

endmodule

`default_nettype wire

// File: design/plim_dp.sv
// gain store, release, limit divider and output register of the peak limiter
`default_nettype none

module plim_dp #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire plim_pkg::plim_cmd_t           cmd,
	output plim_pkg::plim_sts_t                sts,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic [plim_pkg::CH_W-1:0]     channel,
	input  wire logic                          frame_first,
	input  wire logic [plim_pkg::CEIL_W-1:0]   ceiling,
	input  wire logic [plim_pkg::COEF_W-1:0]   release_coef,
	plim_out_if.source                         dout
);
	import plim_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int LW = CEIL_W + SB - 1;   // limit width
	localparam int PW = SB + GAIN_W;       // magnitude times gain
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// captured word
	logic signed [SB-1:0] sample_q;
	logic [CH_W-1:0]      ch_q;
	logic                 first_q;

	// working registers
	logic [GAIN_W-1:0]    gain_q;
	logic [PW-1:0]        prod_q;
	logic [SB-1:0]        rem_q;
	logic [DIV_STEPS-1:0] dq_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [GAIN_W-1:0]    min_q;
	logic [GAIN_W-1:0]    gain_mem_q [CHANNELS];

	// output register
	logic                 out_valid_q;
	logic [SB-1:0]        sample_out_q;
	logic [GAIN_W-1:0]    gain_out_q;
	logic [GAIN_W-1:0]    min_out_q;

	logic                 neg;
	logic [SB-1:0]        mag;
	logic                 ch_ok;
	logic [IW-1:0]        idx;
	logic [GAIN_W-1:0]    gain_rd;
	logic [GAIN_W-1:0]    diff;
	logic [39:0]          rel_prod;
	logic [GAIN_W:0]      rel_sum;
	logic [LW-1:0]        limit;
	logic [SB:0]          trial;
	logic                 trial_ge;
	logic [SB:0]          trial_sub;
	logic [SB-1:0]        res;
	logic [SB-1:0]        res_signed;
	logic [GAIN_W-1:0]    min_base;
	logic [GAIN_W-1:0]    min_new;

	// sample magnitude and channel range
	assign neg   = sample_q[SB-1];
	assign mag   = neg ? (~sample_q + 1'b1) : sample_q;
	assign ch_ok = int'(ch_q) < CHANNELS;
	assign idx   = IW'(ch_q);

	// release toward unity
	assign gain_rd  = ch_ok ? gain_mem_q[idx] : UNITY_GAIN;
	assign diff     = UNITY_GAIN - gain_rd;
	assign rel_prod = 40'(diff) * 40'(release_coef);
	assign rel_sum  = {1'b0, gain_rd} + {1'b0, rel_prod[39:24]};

	// limit check against ceiling scaled to sample full scale
	assign limit    = {ceiling, {(SB-1){1'b0}}};
	assign sts.over = ch_ok && (prod_q > {1'b0, limit});

	// one restoring division step
	assign trial     = {rem_q, dq_q[DIV_STEPS-1]};
	assign trial_ge  = trial >= {1'b0, mag};
	assign trial_sub = trial - {1'b0, mag};

	assign sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.out_full = out_valid_q && !dout.ready;

	// result sample and frame minimum
	assign res        = prod_q[SB+14:15];
	assign res_signed = neg ? (~res + 1'b1) : res;
	assign min_base   = first_q ? UNITY_GAIN : min_q;
	assign min_new    = (ch_ok && gain_q < min_base) ? gain_q : min_base;

	// capture, release, multiply, divide and output word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample_in;
			ch_q     <= channel;
			first_q  <= frame_first;
		end
		if (cmd.rel) begin
			gain_q <= rel_sum[GAIN_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= PW'(mag) * PW'(gain_q);
		end
		if (cmd.div_init) begin
			rem_q <= SB'(limit[LW-1:DIV_STEPS]);
			dq_q  <= limit[DIV_STEPS-1:0];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[SB-1:0] : trial[SB-1:0];
			dq_q  <= {dq_q[DIV_STEPS-2:0], trial_ge};
			cnt_q <= cnt_q + 1'b1;
			if (sts.div_last) begin
				gain_q <= {dq_q[DIV_STEPS-2:0], trial_ge};
			end
		end
		if (cmd.commit) begin
			sample_out_q <= res_signed;
			gain_out_q   <= gain_q;
			min_out_q    <= min_new;
		end
	end

	// per-channel gain and frame minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				gain_mem_q[i] <= UNITY_GAIN;
			end
			min_q <= UNITY_GAIN;
		end else if (cmd.commit) begin
			if (ch_ok) begin
				gain_mem_q[idx] <= gain_q;
			end
			min_q <= min_new;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.sample_out     = sample_out_q;
	assign dout.gain_applied   = gain_out_q;
	assign dout.frame_min_gain = min_out_q;

	// after a cut the gain no longer exceeds the ceiling
	a_cut_settles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul && $past(cmd.div_step)) |=> !sts.over)
		else $error("gain still over the ceiling after division");

	// gains reported never exceed unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (gain_out_q <= UNITY_GAIN && min_out_q <= gain_out_q)
			|| (out_valid_q && min_out_q <= UNITY_GAIN && gain_out_q == UNITY_GAIN))
		else $error("reported gain out of range");

	// a commit always presents a word next cycle
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed word not presented");

endmodule

`default_nettype wire

// File: design/peak_limiter_instant_attack_top.sv
// Peak limiter, instant attack and exponential release, one gain per channel.
// Each accepted word passes the release, multiply and check states; when the
// limit engages, a 16-step restoring divider computes the new gain first.
// A new word is taken only after the previous result has been committed, and
// the commit waits while the output register still holds an untaken word.
// Reset (asynchronous, active low): all channel gains and the frame minimum
// return to unity, ceiling and release coefficient to their defaults.
`default_nettype none

module peak_limiter_instant_attack_top #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	plim_in_if.sink          din,
	plim_out_if.source       dout,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import plim_pkg::*;

	logic [CEIL_W-1:0] ceiling_q;
	logic [COEF_W-1:0] coef_q;
	logic              wr_en;
	logic              in_ready;
	plim_cmd_t         cmd;
	plim_sts_t         sts;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RST;
			coef_q    <= COEF_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_CEILING: ceiling_q <= pwdata[CEIL_W-1:0];
				REG_COEF:    coef_q    <= pwdata[COEF_W-1:0];
				default:     ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			REG_CEILING: prdata = {16'd0, ceiling_q};
			REG_COEF:    prdata = {8'd0, coef_q};
			default:     prdata = '0;
		endcase
	end

	assign din.ready = in_ready;

	plim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plim_dp #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_in    (din.sample_in),
		.channel      (din.channel),
		.frame_first  (din.frame_first),
		.ceiling      (ceiling_q),
		.release_coef (coef_q),
		.dout         (dout)
	);

endmodule

`default_nettype wire
